// ===== src/rnc_pkg.sv =====
`default_nettype none
package rnc_pkg;

	localparam int CWND_FRAC_BITS = 16;
	localparam int RTT_FRAC_BITS  = 8;

	localparam int CW_W       = 32;
	localparam int SEQ_W      = 32;
	localparam int RTO_W      = 16;
	localparam int WIN_W      = 16;
	localparam int SAMP_W     = 16;
	localparam int CNT_W      = 8;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Smoothed RTT and variance hold the sample with its fraction bits.
	localparam int RTT_W  = SAMP_W + RTT_FRAC_BITS;
	// Quotient of 2^(2F) by the window, one bit per divider step.
	localparam int QW     = 2 * CWND_FRAC_BITS + 1;
	localparam int QCNT_W = $clog2(QW);
	localparam int SUM_W  = ((QW > CW_W) ? QW : CW_W) + 1;

	localparam logic [CW_W-1:0] CW_ONE   = {{(CW_W-1){1'b0}}, 1'b1} << CWND_FRAC_BITS;
	localparam logic [CW_W-1:0] CW_TWO   = CW_ONE << 1;
	localparam logic [CW_W-1:0] CW_THREE = CW_ONE + CW_TWO;
	localparam logic [CW_W-1:0] CW_SS0   = CW_ONE << 6;
	localparam logic [CW_W-1:0] CW_MAX   = {CW_W{1'b1}};

	localparam logic [RTO_W-1:0] RTO_MIN   = RTO_W'(50);
	localparam logic [RTO_W-1:0] RTO_MAX   = RTO_W'(60000);
	localparam logic [RTO_W-1:0] RTO_RESET = RTO_W'(200);
	localparam logic [CNT_W-1:0] RETRY_RESET = CNT_W'(20);
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] DUP_THRESH = CNT_W'(3);

	localparam logic [OP_W-1:0] OP_ACK    = 2'd0;
	localparam logic [OP_W-1:0] OP_RTO    = 2'd1;
	localparam logic [OP_W-1:0] OP_SENT   = 2'd2;
	localparam logic [OP_W-1:0] OP_SYNACK = 2'd3;

	localparam logic [1:0] KIND_OLD  = 2'd0;
	localparam logic [1:0] KIND_DUP  = 2'd1;
	localparam logic [1:0] KIND_NEW  = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [1:0] PH_SS = 2'd0;
	localparam logic [1:0] PH_CA = 2'd1;
	localparam logic [1:0] PH_FR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INIT_RTO    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = CFG_IDX_W'(1);

	typedef struct packed {
		logic ready;
		logic exec;
		logic div_step;
		logic add;
		logic rtt1;
		logic rtt2;
		logic load_out;
	} rnc_cmd_t;

	typedef struct packed {
		logic evt_valid;
		logic div_go;
		logic rtt_go;
		logic rtt_pend;
		logic div_last;
		logic out_free;
	} rnc_sts_t;

endpackage
`default_nettype wire

// ===== src/rnc_if.sv =====
`default_nettype none
interface rnc_evt_if;
	logic                       valid;
	logic                       ready;
	logic [rnc_pkg::OP_W-1:0]   operation;
	logic [rnc_pkg::SEQ_W-1:0]  ack_number;
	logic [rnc_pkg::WIN_W-1:0]  peer_window;
	logic                       timestamp_echoed;
	logic [rnc_pkg::SAMP_W-1:0] rtt_sample_ms;
	modport source (output valid, operation, ack_number, peer_window, timestamp_echoed,
		rtt_sample_ms, input ready);
	modport sink (input valid, operation, ack_number, peer_window, timestamp_echoed,
		rtt_sample_ms, output ready);
endinterface

interface rnc_res_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                ack_kind;
	logic                      retransmit;
	logic [rnc_pkg::SEQ_W-1:0] oldest_unacked;
	logic [rnc_pkg::WIN_W-1:0] send_credit;
	logic [rnc_pkg::RTO_W-1:0] timeout_ms;
	logic [1:0]                phase;
	logic                      gave_up;
	modport source (output valid, ack_kind, retransmit, oldest_unacked, send_credit,
		timeout_ms, phase, gave_up, input ready);
	modport sink (input valid, ack_kind, retransmit, oldest_unacked, send_credit,
		timeout_ms, phase, gave_up, output ready);
endinterface

interface rnc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rnc_pkg::CFG_IDX_W-1:0]  index;
	logic [rnc_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/reno_congestion_rto_controller.sv =====
`default_nettype none
// Channel  Role    Word
// evt      sink    one event: operation, ack number, peer window, timestamp flag, RTT sample
// res      source  one result: ack kind, retransmit, oldest unacked, credit, RTO, phase, give-up
// cfg      sink    register write: index 0 initial RTO in ms, index 1 retry limit
//
// An event is taken in the idle state, decoded in the execute state and its result loaded in
// the final state. Taking an RTT sample adds the RTT update states, and a new ACK in
// congestion avoidance adds the divide and add states: the restoring divider forming one over
// the window yields one quotient bit per cycle over 33 bits, then the add state adds it.
// Reset is asynchronous and active low; it loads the state after connection set-up.
// A result waits in the output register while the next event is taken and worked on;
// only the final load stalls when the output is still full.
module reno_congestion_rto_controller (
	input  wire logic clk,
	input  wire logic arst_n,
	rnc_evt_if.sink   evt,
	rnc_res_if.source res,
	rnc_cfg_if.sink   cfg
);
	import rnc_pkg::*;

	// The controller sequences decode, division, window sum, RTT update and result load;
	// the datapath holds all connection state and does the arithmetic.
	rnc_cmd_t cmd;
	rnc_sts_t sts;

	rnc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	rnc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.evt    (evt),
		.res    (res),
		.cfg    (cfg)
	);
endmodule
`default_nettype wire

// ===== src/rnc_ctrl.sv =====
`default_nettype none
module rnc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rnc_pkg::rnc_sts_t sts,
	output rnc_pkg::rnc_cmd_t      cmd
);
	import rnc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_DIV, ST_ADD, ST_RTT1, ST_RTT2, ST_FIN
	} st_t;

	st_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (sts.evt_valid) state_q <= ST_EXEC;
				ST_EXEC: begin
					if (sts.div_go) state_q <= ST_DIV;
					else if (sts.rtt_go) state_q <= ST_RTT1;
					else state_q <= ST_FIN;
				end
				ST_DIV: if (sts.div_last) state_q <= ST_ADD;
				ST_ADD: state_q <= sts.rtt_pend ? ST_RTT1 : ST_FIN;
				ST_RTT1: state_q <= ST_RTT2;
				ST_RTT2: state_q <= ST_FIN;
				ST_FIN: if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.ready    = (state_q == ST_IDLE);
		cmd.exec     = (state_q == ST_EXEC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.add      = (state_q == ST_ADD);
		cmd.rtt1     = (state_q == ST_RTT1);
		cmd.rtt2     = (state_q == ST_RTT2);
		cmd.load_out = (state_q == ST_FIN) && sts.out_free;
	end
endmodule
`default_nettype wire

// ===== src/rnc_datapath.sv =====
`default_nettype none
module rnc_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rnc_pkg::rnc_cmd_t cmd,
	output rnc_pkg::rnc_sts_t      sts,
	rnc_evt_if.sink                evt,
	rnc_res_if.source              res,
	rnc_cfg_if.sink                cfg
);
	import rnc_pkg::*;

	function automatic logic [CW_W-1:0] cw_add(input logic [CW_W-1:0] a,
		input logic [CW_W-1:0] b);
		logic [CW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW_W] ? CW_MAX : s[CW_W-1:0];
	endfunction

	// Latched event word.
	logic [OP_W-1:0]   op_q;
	logic [SEQ_W-1:0]  ack_q;
	logic [WIN_W-1:0]  win_q;
	logic              ts_q;
	logic [SAMP_W-1:0] samp_q;

	// Architectural state.
	logic [CNT_W-1:0] max_retry_q;
	logic [SEQ_W-1:0] una_q, next_q;
	logic [CW_W-1:0]  cwnd_q, ss_q;
	logic [1:0]       phase_q;
	logic [CNT_W-1:0] dup_q, trun_q;
	logic [RTT_W-1:0] srtt_q, rvar_q;
	logic [RTO_W-1:0] rto_q;
	logic             rtt_valid_q, resent_q;
	logic [WIN_W-1:0] peer_q;
	logic             rtt_pend_q;

	// Result of the event.
	logic [1:0] kind_q;
	logic       rtx_q, gave_q;
	logic       ov_q;

	// Divider.
	logic [CW_W-1:0]   dvs_q;
	logic [CW_W:0]     rem_q;
	logic [QW-1:0]     quo_q;
	logic [QCNT_W-1:0] qcnt_q;

	// Event decode.
	logic [SEQ_W-1:0] nx_una, nx_next;
	logic [CW_W-1:0]  nx_cwnd, nx_ss;
	logic [1:0]       nx_phase, nx_kind;
	logic [CNT_W-1:0] nx_dup, nx_trun, dup_inc, trun_inc;
	logic [RTO_W-1:0] nx_rto;
	logic [WIN_W-1:0] nx_peer;
	logic             nx_resent, nx_rtx, nx_gave, div_go, rtt_go;
	logic [CW_W-1:0]  half, cut_ss, ss_step;
	logic [RTO_W:0]   rto_dbl;
	logic             any_flight;

	assign dup_inc    = (dup_q != CNT_MAX) ? dup_q + CNT_W'(1) : dup_q;
	assign trun_inc   = (trun_q != CNT_MAX) ? trun_q + CNT_W'(1) : trun_q;
	assign half       = cwnd_q >> 1;
	assign cut_ss     = (half < CW_TWO) ? CW_TWO : half;
	assign ss_step    = cw_add(cwnd_q, CW_ONE);
	assign rto_dbl    = {rto_q, 1'b0};
	assign any_flight = next_q > una_q;

	always_comb begin
		nx_una = una_q;  nx_next = next_q;  nx_cwnd = cwnd_q;  nx_ss = ss_q;
		nx_phase = phase_q;  nx_dup = dup_q;  nx_trun = trun_q;  nx_rto = rto_q;
		nx_peer = peer_q;  nx_resent = resent_q;
		nx_kind = KIND_NONE;  nx_rtx = 1'b0;  nx_gave = 1'b0;
		div_go = 1'b0;  rtt_go = 1'b0;
		case (op_q)
			OP_ACK: begin
				nx_trun = '0;
				if (ack_q < una_q) begin
					nx_kind = KIND_OLD;
				end else if (ack_q == una_q) begin
					nx_kind = KIND_DUP;
					nx_dup  = dup_inc;
					if (phase_q == PH_FR) begin
						nx_cwnd = ss_step;
					end else if (dup_inc == DUP_THRESH) begin
						nx_ss    = cut_ss;
						nx_cwnd  = cw_add(cut_ss, CW_THREE);
						nx_phase = PH_FR;
						nx_rtx   = any_flight;
						if (any_flight) nx_resent = 1'b1;
					end
				end else begin
					nx_kind   = KIND_NEW;
					nx_dup    = '0;
					rtt_go    = !resent_q && ts_q && (samp_q < RTO_MAX);
					nx_una    = ack_q;
					nx_resent = 1'b0;
					if (next_q < ack_q) nx_next = ack_q;
					case (phase_q)
						PH_SS: begin
							nx_cwnd = ss_step;
							if (ss_step >= ss_q) nx_phase = PH_CA;
						end
						PH_CA: div_go = 1'b1;
						default: begin
							nx_cwnd  = ss_q;
							nx_phase = PH_CA;
						end
					endcase
					if (win_q != '0) nx_peer = win_q;
				end
			end
			OP_RTO: begin
				nx_trun = trun_inc;
				if (trun_inc > max_retry_q) begin
					nx_gave = 1'b1;
				end else begin
					nx_ss    = cut_ss;
					nx_cwnd  = CW_ONE;
					nx_phase = PH_SS;
					nx_dup   = '0;
					nx_rto   = (rto_dbl > {1'b0, RTO_MAX}) ? RTO_MAX : rto_dbl[RTO_W-1:0];
					nx_rtx   = any_flight;
					if (any_flight) nx_resent = 1'b1;
				end
			end
			OP_SENT: begin
				if (next_q != {SEQ_W{1'b1}}) nx_next = next_q + SEQ_W'(1);
			end
			default: begin
				nx_peer = (win_q != '0) ? win_q : WIN_W'(1);
				rtt_go  = 1'b1;
			end
		endcase
	end

	// Divider step and window sum.
	logic [CW_W:0]    rem_sh;
	logic             q_bit;
	logic [SUM_W-1:0] cw_sum;

	assign rem_sh = {rem_q[CW_W-1:0], (qcnt_q == QCNT_W'(2 * CWND_FRAC_BITS))};
	assign q_bit  = rem_sh >= {1'b0, dvs_q};
	assign cw_sum = SUM_W'(cwnd_q) + SUM_W'(quo_q);

	// RTT estimator.
	logic [RTT_W-1:0] s_fix, rdiff;
	logic [RTT_W+1:0] var_sum;
	logic [RTT_W+2:0] srtt_sum, rto_t;
	logic [RTT_W+2-RTT_FRAC_BITS:0] rto_ms;

	assign s_fix    = {samp_q, {RTT_FRAC_BITS{1'b0}}};
	assign rdiff    = (srtt_q > s_fix) ? srtt_q - s_fix : s_fix - srtt_q;
	assign var_sum  = (RTT_W+2)'(rvar_q) * (RTT_W+2)'(3) + (RTT_W+2)'(rdiff);
	assign srtt_sum = (RTT_W+3)'(srtt_q) * (RTT_W+3)'(7) + (RTT_W+3)'(s_fix);
	assign rto_t    = (RTT_W+3)'(srtt_q) + ((RTT_W+3)'(rvar_q) << 2)
		+ (RTT_W+3)'((1 << RTT_FRAC_BITS) - 1);
	assign rto_ms   = rto_t[RTT_W+2:RTT_FRAC_BITS];

	// Send credit from the state after the event.
	logic [CW_W-1:0]  eff_full, eff_min;
	logic [WIN_W-1:0] eff;
	logic [SEQ_W-1:0] flight;
	logic [WIN_W-1:0] credit;

	assign eff_full = cwnd_q >> CWND_FRAC_BITS;
	assign eff_min  = (eff_full > CW_W'(peer_q)) ? CW_W'(peer_q) : eff_full;
	assign eff      = (eff_min == '0) ? WIN_W'(1) : eff_min[WIN_W-1:0];
	assign flight   = (next_q > una_q) ? next_q - una_q : '0;
	assign credit   = (SEQ_W'(eff) > flight) ? eff - flight[WIN_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retry_q <= RETRY_RESET;
			una_q       <= SEQ_W'(1);
			next_q      <= SEQ_W'(1);
			cwnd_q      <= CW_ONE;
			ss_q        <= CW_SS0;
			phase_q     <= PH_SS;
			dup_q       <= '0;
			trun_q      <= '0;
			srtt_q      <= '0;
			rvar_q      <= '0;
			rto_q       <= RTO_RESET;
			rtt_valid_q <= 1'b0;
			resent_q    <= 1'b0;
			peer_q      <= WIN_W'(1);
			rtt_pend_q  <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_INIT_RTO) begin
					if (!rtt_valid_q) begin
						if (cfg.data == '0) rto_q <= RTO_W'(1);
						else if (cfg.data > RTO_MAX) rto_q <= RTO_MAX;
						else rto_q <= cfg.data;
					end
				end else if (cfg.index == REG_MAX_RETRIES) begin
					max_retry_q <= cfg.data[CNT_W-1:0];
				end
			end
			if (cmd.exec) begin
				una_q <= nx_una;  next_q <= nx_next;  cwnd_q <= nx_cwnd;  ss_q <= nx_ss;
				phase_q <= nx_phase;  dup_q <= nx_dup;  trun_q <= nx_trun;
				rto_q <= nx_rto;  peer_q <= nx_peer;  resent_q <= nx_resent;
				rtt_pend_q <= rtt_go;
			end
			if (cmd.add) begin
				cwnd_q <= (cw_sum > SUM_W'(CW_MAX)) ? CW_MAX : cw_sum[CW_W-1:0];
			end
			if (cmd.rtt1) begin
				rtt_valid_q <= 1'b1;
				if (!rtt_valid_q) begin
					srtt_q <= s_fix;
					rvar_q <= s_fix >> 1;
				end else begin
					rvar_q <= var_sum[RTT_W+1:2];
					srtt_q <= srtt_sum[RTT_W+2:3];
				end
			end
			if (cmd.rtt2) begin
				if (rto_ms < (RTT_W+3-RTT_FRAC_BITS)'(RTO_MIN)) rto_q <= RTO_MIN;
				else if (rto_ms > (RTT_W+3-RTT_FRAC_BITS)'(RTO_MAX)) rto_q <= RTO_MAX;
				else rto_q <= rto_ms[RTO_W-1:0];
			end
			if (cmd.load_out) ov_q <= 1'b1;
			else if (res.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && cmd.ready) begin
			op_q   <= evt.operation;
			ack_q  <= evt.ack_number;
			win_q  <= evt.peer_window;
			ts_q   <= evt.timestamp_echoed;
			samp_q <= evt.rtt_sample_ms;
		end
		if (cmd.exec) begin
			kind_q <= nx_kind;
			rtx_q  <= nx_rtx;
			gave_q <= nx_gave;
			dvs_q  <= cwnd_q;
			rem_q  <= '0;
			quo_q  <= '0;
			qcnt_q <= QCNT_W'(QW - 1);
		end
		if (cmd.div_step) begin
			rem_q  <= q_bit ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quo_q  <= {quo_q[QW-2:0], q_bit};
			qcnt_q <= qcnt_q - QCNT_W'(1);
		end
		if (cmd.load_out) begin
			res.ack_kind       <= kind_q;
			res.retransmit     <= rtx_q;
			res.oldest_unacked <= una_q;
			res.send_credit    <= credit;
			res.timeout_ms     <= rto_q;
			res.phase          <= phase_q;
			res.gave_up        <= gave_q;
		end
	end

	assign evt.ready = cmd.ready;
	assign cfg.ready = 1'b1;
	assign res.valid = ov_q;

	always_comb begin
		sts           = '0;
		sts.evt_valid = evt.valid;
		sts.div_go    = div_go;
		sts.rtt_go    = rtt_go;
		sts.rtt_pend  = rtt_pend_q;
		sts.div_last  = (qcnt_q == '0);
		sts.out_free  = !ov_q || res.ready;
	end
endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the Reno congestion and RTO controller.
// Each event word sent to the block is run through a local model of the
// sender state at the moment it is accepted, and the predicted result word is
// queued. A monitor compares every result word taken from the block with the
// oldest queued prediction, field by field.
module testbench;
	import rnc_pkg::*;

	localparam longint CYCLE_LIMIT = 1000000;
	localparam logic [63:0] W_ONE = 64'd1 << CWND_FRAC_BITS;
	localparam logic [63:0] W_MAX = 64'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  ack_kind;
		logic        retransmit;
		logic [31:0] oldest_unacked;
		logic [15:0] send_credit;
		logic [15:0] timeout_ms;
		logic [1:0]  phase;
		logic        gave_up;
	} verdict_t;

	logic clk;
	logic arst_n;

	rnc_evt_if evt_ch();
	rnc_res_if res_ch();
	rnc_cfg_if cfg_ch();

	reno_congestion_rto_controller DUT (
		.clk(clk),
		.arst_n(arst_n),
		.evt(evt_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// The clock runs with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Shadow copy of the sender state, advanced once per accepted event word.
	logic [7:0]  sh_retry_limit;
	logic [31:0] sh_una;
	logic [31:0] sh_next;
	logic [63:0] sh_cwnd;
	logic [63:0] sh_ssthresh;
	logic [1:0]  sh_phase;
	logic [7:0]  sh_dups;
	logic [63:0] sh_srtt;
	logic [63:0] sh_rttvar;
	logic [15:0] sh_rto;
	logic        sh_rtt_known;
	logic [15:0] sh_peer_win;
	logic        sh_resent;
	logic [7:0]  sh_timeouts;

	verdict_t expected_q[$];
	int  errors;
	int  events_sent;
	int  verdicts_seen;
	int  resends_seen;
	int  giveups_seen;
	longint cycles;
	// When set, the sender never pauses between words; toggled by the tests.
	bit  burst_mode;

	function automatic logic [63:0] window_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > W_MAX) ? W_MAX : s;
	endfunction

	function automatic void take_rtt(logic [15:0] sample);
		logic [63:0] s;
		logic [63:0] d;
		logic [63:0] t;
		s = 64'(sample) << RTT_FRAC_BITS;
		if (!sh_rtt_known) begin
			sh_srtt = s;
			sh_rttvar = s >> 1;
			sh_rtt_known = 1'b1;
		end else begin
			d = (sh_srtt > s) ? sh_srtt - s : s - sh_srtt;
			sh_rttvar = (3 * sh_rttvar + d) >> 2;
			sh_srtt = (7 * sh_srtt + s) >> 3;
		end
		t = sh_srtt + 4 * sh_rttvar;
		t = (t + (64'd1 << RTT_FRAC_BITS) - 1) >> RTT_FRAC_BITS;
		if (t < 64'(RTO_MIN)) t = 64'(RTO_MIN);
		if (t > 64'(RTO_MAX)) t = 64'(RTO_MAX);
		sh_rto = t[15:0];
	endfunction

	function automatic void halve_threshold();
		logic [63:0] h;
		h = sh_cwnd >> 1;
		sh_ssthresh = (h < 2 * W_ONE) ? 2 * W_ONE : h;
	endfunction

	// Resending is only asked for when something is actually in flight.
	function automatic logic resend_oldest();
		if (sh_next > sh_una) begin
			sh_resent = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [15:0] clamp_timeout(logic [63:0] v);
		if (v < 1) return 16'd1;
		return (v > 64'(RTO_MAX)) ? RTO_MAX : v[15:0];
	endfunction

	function automatic void shadow_reset();
		sh_retry_limit = RETRY_RESET;
		sh_una = 32'd1;
		sh_next = 32'd1;
		sh_cwnd = W_ONE;
		sh_ssthresh = 64 * W_ONE;
		sh_phase = PH_SS;
		sh_dups = 8'd0;
		sh_srtt = 64'd0;
		sh_rttvar = 64'd0;
		sh_rto = RTO_RESET;
		sh_rtt_known = 1'b0;
		sh_peer_win = 16'd1;
		sh_resent = 1'b0;
		sh_timeouts = 8'd0;
	endfunction

	function automatic void shadow_write_reg(logic [7:0] idx, logic [15:0] value);
		if (idx == REG_INIT_RTO) begin
			if (!sh_rtt_known) sh_rto = clamp_timeout(64'(value));
		end else if (idx == REG_MAX_RETRIES) begin
			sh_retry_limit = value[7:0];
		end
	endfunction

	// Advances the shadow state by one event and returns the result word it implies.
	function automatic verdict_t congestion_step(logic [1:0] op, logic [31:0] ack,
			logic [15:0] win, logic ts, logic [15:0] sample);
		verdict_t v;
		logic [63:0] eff;
		logic [63:0] flight;
		logic [63:0] inc;
		v = '0;
		v.ack_kind = KIND_NONE;
		if (op == OP_ACK) begin
			sh_timeouts = 8'd0;
			if (ack < sh_una) begin
				v.ack_kind = KIND_OLD;
			end else if (ack == sh_una) begin
				v.ack_kind = KIND_DUP;
				if (sh_dups != CNT_MAX) sh_dups++;
				if (sh_phase == PH_FR) begin
					sh_cwnd = window_add(sh_cwnd, W_ONE);
				end else if (sh_dups == DUP_THRESH) begin
					// Third duplicate: fast retransmit and enter recovery.
					halve_threshold();
					sh_cwnd = window_add(sh_ssthresh, 3 * W_ONE);
					sh_phase = PH_FR;
					v.retransmit = resend_oldest();
				end
			end else begin
				v.ack_kind = KIND_NEW;
				sh_dups = 8'd0;
				// Karn: no sample is taken when the acked segment was resent.
				if (!sh_resent && ts && sample < RTO_MAX) take_rtt(sample);
				sh_una = ack;
				sh_resent = 1'b0;
				if (sh_next < ack) sh_next = ack;
				if (sh_phase == PH_SS) begin
					sh_cwnd = window_add(sh_cwnd, W_ONE);
					if (sh_cwnd >= sh_ssthresh) sh_phase = PH_CA;
				end else if (sh_phase == PH_CA) begin
					inc = (sh_cwnd != 0) ? (W_ONE * W_ONE) / sh_cwnd : W_MAX;
					sh_cwnd = window_add(sh_cwnd, inc);
				end else begin
					sh_cwnd = sh_ssthresh;
					sh_phase = PH_CA;
				end
				if (win != 0) sh_peer_win = win;
			end
		end else if (op == OP_RTO) begin
			if (sh_timeouts != CNT_MAX) sh_timeouts++;
			if (sh_timeouts > sh_retry_limit) begin
				v.gave_up = 1'b1;
			end else begin
				halve_threshold();
				sh_cwnd = W_ONE;
				sh_phase = PH_SS;
				sh_dups = 8'd0;
				sh_rto = clamp_timeout(64'(sh_rto) * 2);
				v.retransmit = resend_oldest();
			end
		end else if (op == OP_SENT) begin
			if (sh_next != 32'hFFFF_FFFF) sh_next++;
		end else begin
			sh_peer_win = (win != 0) ? win : 16'd1;
			take_rtt(sample);
		end
		eff = sh_cwnd >> CWND_FRAC_BITS;
		if (eff > 64'(sh_peer_win)) eff = 64'(sh_peer_win);
		if (eff < 1) eff = 1;
		flight = (sh_next > sh_una) ? 64'(sh_next - sh_una) : 64'd0;
		v.send_credit = (eff > flight) ? 16'(eff - flight) : 16'd0;
		v.oldest_unacked = sh_una;
		v.timeout_ms = sh_rto;
		v.phase = sh_phase;
		return v;
	endfunction

	// Mostly back-to-back words, some short pauses and the odd long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Presents one event word, waits for it to be taken and records the prediction.
	// The valid line is left high when the next word follows at once.
	task automatic send_event(logic [1:0] op, logic [31:0] ack, logic [15:0] win,
			logic ts, logic [15:0] sample);
		int gap;
		evt_ch.valid <= 1'b1;
		evt_ch.operation <= op;
		evt_ch.ack_number <= ack;
		evt_ch.peer_window <= win;
		evt_ch.timestamp_echoed <= ts;
		evt_ch.rtt_sample_ms <= sample;
		do @(posedge clk); while (!evt_ch.ready);
		expected_q.push_back(congestion_step(op, ack, win, ts, sample));
		events_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lets every outstanding result word drain, then allows for the deepest
	// pipeline latency (a divide plus an RTT update) before touching registers.
	task automatic drain();
		evt_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [15:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		shadow_write_reg(idx, value);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: the receiver stalls at random, with calm stretches now and then.
	int stall_left;
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if ((cycles / 700) % 3 == 0 || r < 70) begin
			res_ch.ready <= 1'b1;
		end else if (r < 95) begin
			res_ch.ready <= 1'b0;
			stall_left <= $urandom_range(0, 3);
		end else begin
			res_ch.ready <= 1'b0;
			stall_left <= $urandom_range(10, 40);
		end
	end

	// Every result word taken is checked against the oldest prediction.
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			verdicts_seen++;
			if (expected_q.size() == 0) begin
				$error("result word with no prediction waiting");
				errors++;
			end else begin
				exp_v = expected_q.pop_front();
				if (res_ch.retransmit) resends_seen++;
				if (res_ch.gave_up) giveups_seen++;
				if (res_ch.ack_kind !== exp_v.ack_kind) begin
					$error("ack_kind expected %0d got %0d", exp_v.ack_kind, res_ch.ack_kind);
					errors++;
				end
				if (res_ch.retransmit !== exp_v.retransmit) begin
					$error("retransmit expected %0d got %0d", exp_v.retransmit,
						res_ch.retransmit);
					errors++;
				end
				if (res_ch.oldest_unacked !== exp_v.oldest_unacked) begin
					$error("oldest_unacked expected %0h got %0h", exp_v.oldest_unacked,
						res_ch.oldest_unacked);
					errors++;
				end
				if (res_ch.send_credit !== exp_v.send_credit) begin
					$error("send_credit expected %0d got %0d", exp_v.send_credit,
						res_ch.send_credit);
					errors++;
				end
				if (res_ch.timeout_ms !== exp_v.timeout_ms) begin
					$error("timeout_ms expected %0d got %0d", exp_v.timeout_ms,
						res_ch.timeout_ms);
					errors++;
				end
				if (res_ch.phase !== exp_v.phase) begin
					$error("phase expected %0d got %0d", exp_v.phase, res_ch.phase);
					errors++;
				end
				if (res_ch.gave_up !== exp_v.gave_up) begin
					$error("gave_up expected %0d got %0d", exp_v.gave_up, res_ch.gave_up);
					errors++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The initial RTO register is only loaded into the live timeout while no RTT
	// sample exists, so its whole range is swept before the first sample.
	task automatic test_initial_rto();
		write_reg(REG_INIT_RTO, 16'd0);
		send_event(OP_SENT, 32'd0, 16'd0, 1'b0, 16'd0);
		write_reg(REG_INIT_RTO, 16'hFFFF);
		send_event(OP_SENT, 32'd0, 16'd0, 1'b0, 16'd0);
		write_reg(REG_INIT_RTO, RTO_MAX);
		send_event(OP_RTO, 32'd0, 16'd0, 1'b0, 16'd0);
		write_reg(REG_INIT_RTO, 16'd1);
		send_event(OP_RTO, 32'd0, 16'd0, 1'b0, 16'd0);
		write_reg(REG_INIT_RTO, RTO_RESET);
		send_event(OP_ACK, sh_una, 16'd0, 1'b0, 16'd0);
	endtask

	// Short scripted walk through slow start, fast retransmit and recovery.
	task automatic test_reno_walk();
		repeat (5) send_event(OP_SENT, 32'd0, 16'd0, 1'b0, 16'd0);
		// First RTT sample seeds the smoothed values.
		send_event(OP_ACK, sh_una + 2, 16'd40, 1'b1, 16'd100);
		// Three duplicates give a fast retransmit; a fourth inflates the window.
		repeat (4) send_event(OP_ACK, sh_una, 16'd0, 1'b0, 16'd0);
		send_event(OP_ACK, sh_una + 1, 16'd0, 1'b1, 16'd60000);
		send_event(OP_ACK, 32'd0, 16'hFFFF, 1'b1, 16'hFFFF);
		// An ACK beyond the send point pulls the send point up with it.
		send_event(OP_ACK, sh_next + 7, 16'hFFFF, 1'b1, 16'hFFFF);
		send_event(OP_RTO, 32'd0, 16'd0, 1'b0, 16'd0);
		send_event(OP_SENT, 32'd0, 16'd0, 1'b0, 16'd0);
		send_event(OP_RTO, 32'd0, 16'd0, 1'b0, 16'd0);
		// The resent segment's sample must be ignored.
		send_event(OP_ACK, sh_una + 1, 16'd0, 1'b1, 16'd5);
		send_event(OP_SYNACK, 32'hFFFF_FFFF, 16'd0, 1'b1, 16'd0);
		send_event(OP_SYNACK, 32'd0, 16'hFFFF, 1'b0, 16'hFFFF);
		// With a sample present the register no longer moves the timeout.
		write_reg(REG_INIT_RTO, 16'd777);
		write_reg(REG_MAX_RETRIES, 16'd0);
		send_event(OP_SENT, 32'd0, 16'd0, 1'b0, 16'd0);
		repeat (2) send_event(OP_RTO, 32'd0, 16'd0, 1'b0, 16'd0);
		write_reg(REG_MAX_RETRIES, 16'(RETRY_RESET));
	endtask

	task automatic random_event();
		int r;
		logic [63:0] top;
		logic [31:0] flight;
		r = $urandom_range(0, 99);
		flight = (sh_next > sh_una) ? sh_next - sh_una : 32'd0;
		if (r < 28 || sh_una == 32'hFFFF_FFFF) begin
			repeat ($urandom_range(1, 4))
				send_event(OP_SENT, $urandom, 16'($urandom), 1'($urandom), 16'($urandom));
		end else if (r < 52) begin
			top = 64'(sh_una) + 64'(flight) + (($urandom_range(0, 9) == 0) ? 5 : 0);
			if (top <= 64'(sh_una)) top = 64'(sh_una) + 1;
			if (top > W_MAX) top = W_MAX;
			send_event(OP_ACK, 32'(64'(sh_una) + $urandom_range(1, 32'(top - sh_una))),
				($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64)),
				1'($urandom),
				($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000)));
		end else if (r < 68) begin
			repeat ($urandom_range(1, 6))
				send_event(OP_ACK, sh_una, 16'($urandom), 1'($urandom), 16'($urandom));
		end else if (r < 76) begin
			send_event(OP_RTO, $urandom, 16'($urandom), 1'($urandom), 16'($urandom));
		end else if (r < 81 && sh_una != 0) begin
			send_event(OP_ACK, $urandom_range(0, sh_una - 1), 16'($urandom), 1'($urandom),
				16'($urandom));
		end else if (r < 85) begin
			send_event(OP_SYNACK, $urandom, 16'($urandom_range(0, 3)), 1'($urandom),
				16'($urandom));
		end else begin
			send_event(2'($urandom), $urandom, 16'($urandom), 1'($urandom), 16'($urandom));
		end
	endtask

	// Random traffic in blocks, with the registers changed after every fifth block.
	task automatic test_random_traffic(int count);
		int block;
		block = 0;
		while (events_sent < count) begin
			burst_mode = ($urandom_range(0, 4) == 0);
			repeat (60) random_event();
			block++;
			if (block % 5 == 0) begin
				write_reg(REG_MAX_RETRIES, 16'($urandom_range(0, 6)));
				write_reg(REG_INIT_RTO, 16'($urandom));
			end
		end
		burst_mode = 1'b0;
	endtask

	// A limit of 255 never gives up, however long the run of timeouts.
	task automatic test_retry_ceiling();
		write_reg(REG_MAX_RETRIES, 16'(CNT_MAX));
		repeat (260) send_event(OP_RTO, 32'd0, 16'd0, 1'b0, 16'd0);
		send_event(OP_ACK, 32'd0, 16'd0, 1'b0, 16'd0);
	endtask

	// Sequence numbers at the top of their range: the send point saturates.
	task automatic test_sequence_top();
		send_event(OP_ACK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 16'd59999);
		repeat (2) send_event(OP_SENT, 32'd0, 16'd0, 1'b0, 16'd0);
		send_event(OP_ACK, 32'hFFFF_FFFF, 16'd0, 1'b0, 16'd0);
		send_event(OP_ACK, 32'hFFFF_FFFE, 16'd0, 1'b0, 16'd0);
		send_event(OP_RTO, 32'd0, 16'd0, 1'b0, 16'd0);
	endtask

	initial begin
		arst_n = 1'b0;
		evt_ch.valid = 1'b0;
		evt_ch.operation = OP_ACK;
		evt_ch.ack_number = '0;
		evt_ch.peer_window = '0;
		evt_ch.timestamp_echoed = 1'b0;
		evt_ch.rtt_sample_ms = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_INIT_RTO;
		cfg_ch.data = '0;
		errors = 0;
		events_sent = 0;
		verdicts_seen = 0;
		resends_seen = 0;
		giveups_seen = 0;
		cycles = 0;
		stall_left = 0;
		burst_mode = 1'b0;
		shadow_reset();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_initial_rto();
		test_reno_walk();
		test_random_traffic(1000);
		test_retry_ceiling();
		test_sequence_top();

		drain();
		$display("Covered %0d event words and %0d result words, %0d retransmits, %0d give-ups.",
			events_sent, verdicts_seen, resends_seen, giveups_seen);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== reno_congestion_rto_controller.f =====
src/rnc_pkg.sv
src/rnc_if.sv
src/rnc_ctrl.sv
src/rnc_datapath.sv
src/reno_congestion_rto_controller.sv
verif/testbench.sv
